// ===== src/fotr_pkg.sv =====
// Shared types and constants of the FAT16 file offset translator.
`timescale 1ns / 1ps
`default_nettype none
package fotr_pkg;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_OPEN  = 2'd1,
		OP_SEEK  = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FILE  = 3'd1,
		ST_BAD_SEEK  = 3'd2,
		ST_CHAIN_END = 3'd3,
		ST_OUTSIDE   = 3'd4,
		ST_EOF       = 3'd5
	} status_t;

	localparam logic [2:0] CFG_BPS      = 3'd0;
	localparam logic [2:0] CFG_SPC      = 3'd1;
	localparam logic [2:0] CFG_RESERVED = 3'd2;
	localparam logic [2:0] CFG_COPIES   = 3'd3;
	localparam logic [2:0] CFG_SPT      = 3'd4;
	localparam logic [2:0] CFG_ROOT     = 3'd5;

	localparam logic [15:0] END_MARK    = 16'hFFF8;
	localparam logic [7:0]  ATTR_DIR    = 8'h10;
	localparam logic [7:0]  ATTR_VOLUME = 8'h08;
	localparam logic [15:0] FIRST_DATA  = 16'd2;
	localparam int          RESULTS_MAX = 33;

	typedef struct packed {
		logic [12:0] bps;
		logic [7:0]  spc;
		logic [15:0] reserved;
		logic [2:0]  copies;
		logic [15:0] spt;
		logic [15:0] root;
	} cfg_t;

	typedef struct packed {
		op_t         op;
		logic        bad_index;
		logic        reject;
		logic [15:0] table_index;
		logic [15:0] table_value;
		logic [15:0] start_cluster;
		logic [31:0] file_length;
		logic [32:0] seek_offset;
		logic [1:0]  seek_origin;
		logic [14:0] read_length;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [35:0] disk_address;
		logic [14:0] segment_bytes;
		logic [31:0] file_position;
		logic [15:0] cluster_now;
		logic        last;
	} result_t;

endpackage
`default_nettype wire

// ===== src/fotr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fotr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== src/fotr_front.sv =====
// Front end: takes commands, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module fotr_front import fotr_pkg::*; #(
	parameter int TABLE_ENTRIES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  op,
	input  wire logic [15:0] table_index,
	input  wire logic [15:0] table_value,
	input  wire logic [15:0] start_cluster,
	input  wire logic [7:0]  attributes,
	input  wire logic [31:0] file_length,
	input  wire logic [32:0] seek_offset,
	input  wire logic [1:0]  seek_origin,
	input  wire logic [14:0] read_length,
	output logic             cmd_valid,
	output cmd_t             cmd,
	input  wire logic        cmd_pop
);

	localparam logic [16:0] TE17 = 17'(TABLE_ENTRIES);

	cmd_t       ent_q [2];
	cmd_t       new_cmd;
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       accept;
	logic       pop;

	always_comb begin
		new_cmd               = '0;
		new_cmd.op            = op_t'(op);
		new_cmd.bad_index     = ({1'b0, table_index} >= TE17);
		new_cmd.reject        = |(attributes & (ATTR_DIR | ATTR_VOLUME));
		new_cmd.table_index   = table_index;
		new_cmd.table_value   = table_value;
		new_cmd.start_cluster = start_cluster;
		new_cmd.file_length   = file_length;
		new_cmd.seek_offset   = seek_offset;
		new_cmd.seek_origin   = seek_origin;
		new_cmd.read_length   = read_length;
	end

	assign busy      = cnt_q[1];
	assign accept    = start && !busy;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_q[wptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (accept) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (accept && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !accept) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/fotr_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module fotr_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [31:0] dividend,
	input  wire logic [20:0] divisor,
	output logic             done,
	output logic [31:0]      quotient,
	output logic [20:0]      remainder
);

	localparam int DIV_STEPS = 32;

	logic [31:0] dvd_q;
	logic [20:0] dvs_q;
	logic [20:0] rem_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [21:0] trial;
	logic [21:0] diff;
	logic        ge;

	assign trial     = {rem_q, dvd_q[31]};
	assign diff      = trial - {1'b0, dvs_q};
	assign ge        = (trial >= {1'b0, dvs_q});
	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[30:0], ge};
			rem_q <= ge ? diff[20:0] : trial[20:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= 6'(DIV_STEPS);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/fotr_back.sv =====
// Back end: holds the open file and the allocation table and executes commands.
`timescale 1ns / 1ps
`default_nettype none
module fotr_back import fotr_pkg::*; #(
	parameter int TABLE_ENTRIES = 4096
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  cfg_t      cfg,
	input  wire logic cmd_valid,
	input  cmd_t      cmd,
	output logic      cmd_pop,
	output result_t   res,
	output logic      res_strobe
);

	localparam int          AW   = $clog2(TABLE_ENTRIES);
	localparam logic [16:0] TE17 = 17'(TABLE_ENTRIES);
	localparam logic [1:0]  ORG_SET = 2'd0;
	localparam logic [1:0]  ORG_CUR = 2'd1;
	localparam logic [1:0]  ORG_END = 2'd2;
	localparam logic [1:0]  ORG_BAD = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_SK_DIV, S_SK_WALK, S_SK_LOAD,
		S_RD_POS, S_RD_ROOT, S_RD_CHECK, S_RD_ADDR, S_RD_EMIT
	} state_t;

	state_t      state_q;
	cmd_t        cmd_q;
	logic [15:0] first_q;
	logic [15:0] cur_q;
	logic [31:0] pos_q;
	logic [31:0] size_q;
	logic        open_q;
	result_t     res_q;
	logic        strobe_q;

	logic [31:0] tgt_q;
	logic [16:0] hops_q;
	logic [16:0] i_q;
	logic [15:0] c_q;
	logic [14:0] len_q;
	logic [14:0] done_cnt_q;
	logic [20:0] inner_q;
	logic [22:0] base_q;
	logic [25:0] sec_q;
	logic [14:0] seg_q;
	logic [35:0] addr_q;
	logic [15:0] nxt_q;
	logic        bnd_q;
	logic [5:0]  k_q;

	logic        div_go_q;
	logic [31:0] dvd_q;
	logic [20:0] dvs_q;
	logic        div_done;
	logic [31:0] div_quot;
	logic [20:0] div_rem;

	logic        ram_we;
	logic        ram_re;
	logic [AW-1:0] ram_raddr;
	logic [15:0] ram_rdata;

	logic [12:0] bps_e;
	logic [7:0]  spc_e;
	logic [20:0] cs;
	logic [31:0] org_base;
	logic [33:0] target;
	logic        seek_bad;
	logic        at_eof;
	logic [31:0] remain;
	logic [14:0] len_n;
	logic        w_done;
	logic        w_end;
	logic        w_out;
	logic        walk_go;
	logic        c_end;
	logic        c_out;
	logic        seg_go;
	logic [20:0] room;
	logic [14:0] left;
	logic [14:0] seg_n;
	logic [15:0] c_off;
	logic [23:0] prod24;
	logic [25:0] sec_n;
	logic [38:0] prod39;
	logic [35:0] addr_n;
	logic [31:0] root_dvd;
	logic [18:0] tbl_sectors;
	logic        last_n;

	function automatic result_t mk(status_t st, logic [35:0] addr, logic [14:0] seg,
			logic [31:0] pos, logic [15:0] clu, logic lst);
		result_t r;
		r.status        = st;
		r.disk_address  = addr;
		r.segment_bytes = seg;
		r.file_position = pos;
		r.cluster_now   = clu;
		r.last          = lst;
		return r;
	endfunction

	assign bps_e = (cfg.bps == 13'd0) ? 13'd1 : cfg.bps;
	assign spc_e = (cfg.spc == 8'd0) ? 8'd1 : cfg.spc;
	assign cs    = {8'b0, bps_e} * {13'b0, spc_e};

	always_comb begin
		case (cmd_q.seek_origin)
			ORG_SET: org_base = 32'd0;
			ORG_CUR: org_base = pos_q;
			ORG_END: org_base = size_q;
			default: org_base = 32'd0;
		endcase
	end

	assign target   = {2'b00, org_base} + {cmd_q.seek_offset[32], cmd_q.seek_offset};
	assign seek_bad = !open_q || (cmd_q.seek_origin == ORG_BAD) || target[33]
		|| (target[32:0] > {1'b0, size_q});

	assign at_eof = !open_q || (pos_q >= size_q);
	assign remain = size_q - pos_q;
	assign len_n  = (remain < {17'b0, cmd_q.read_length}) ? remain[14:0] : cmd_q.read_length;

	assign w_done  = (i_q == hops_q);
	assign w_end   = (c_q >= END_MARK);
	assign w_out   = ({1'b0, c_q} >= TE17);
	assign walk_go = !w_done && !w_end && !w_out;

	assign c_end  = (cur_q >= END_MARK);
	assign c_out  = (cur_q < FIRST_DATA) || ({1'b0, cur_q} >= TE17);
	assign seg_go = !c_end && !c_out;
	assign room   = cs - inner_q;
	assign left   = len_q - done_cnt_q;
	assign seg_n  = ({6'b0, left} < room) ? left : room[14:0];
	assign c_off  = cur_q - FIRST_DATA;
	assign prod24 = {8'b0, c_off} * {16'b0, spc_e};
	assign sec_n  = {3'b0, base_q} + {2'b0, prod24};
	assign prod39 = {13'b0, sec_q} * {26'b0, bps_e};
	assign addr_n = prod39[35:0] + {15'b0, inner_q};

	// Root directory sectors are rounded up: (entries * 32 + sector - 1) / sector.
	assign root_dvd    = {11'b0, cfg.root, 5'b0} + {19'b0, bps_e} - 32'd1;
	assign tbl_sectors = {16'b0, cfg.copies} * {3'b0, cfg.spt};

	assign last_n = (done_cnt_q == len_q) || (k_q == 6'(RESULTS_MAX - 1));

	assign cmd_pop    = (state_q == S_IDLE) && cmd_valid;
	assign res        = res_q;
	assign res_strobe = strobe_q;

	assign ram_we    = (state_q == S_EXEC) && (cmd_q.op == OP_WRITE) && !cmd_q.bad_index;
	assign ram_re    = ((state_q == S_SK_WALK) && walk_go) || ((state_q == S_RD_CHECK) && seg_go);
	assign ram_raddr = (state_q == S_SK_WALK) ? c_q[AW-1:0] : cur_q[AW-1:0];

	fotr_ram #(
		.WIDTH(16),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cmd_q.table_index[AW-1:0]),
		.wdata(cmd_q.table_value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	fotr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go_q),
		.dividend (dvd_q),
		.divisor  (dvs_q),
		.done     (div_done),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			first_q  <= '0;
			cur_q    <= '0;
			pos_q    <= '0;
			size_q   <= '0;
			open_q   <= 1'b0;
			strobe_q <= 1'b0;
			div_go_q <= 1'b0;
			k_q      <= '0;
		end else begin
			strobe_q <= 1'b0;
			div_go_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (cmd_q.op)
						OP_WRITE: begin
							res_q    <= mk(cmd_q.bad_index ? ST_OUTSIDE : ST_OK, '0, '0,
								pos_q, cur_q, 1'b1);
							strobe_q <= 1'b1;
							state_q  <= S_IDLE;
						end
						OP_OPEN: begin
							if (cmd_q.reject) begin
								res_q <= mk(ST_NOT_FILE, '0, '0, pos_q, cur_q, 1'b1);
							end else begin
								first_q <= cmd_q.start_cluster;
								cur_q   <= cmd_q.start_cluster;
								pos_q   <= '0;
								size_q  <= cmd_q.file_length;
								open_q  <= 1'b1;
								res_q   <= mk(ST_OK, '0, '0, '0, cmd_q.start_cluster, 1'b1);
							end
							strobe_q <= 1'b1;
							state_q  <= S_IDLE;
						end
						OP_SEEK: begin
							if (seek_bad) begin
								res_q    <= mk(ST_BAD_SEEK, '0, '0, pos_q, cur_q, 1'b1);
								strobe_q <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								tgt_q    <= target[31:0];
								dvd_q    <= target[31:0];
								dvs_q    <= cs;
								div_go_q <= 1'b1;
								state_q  <= S_SK_DIV;
							end
						end
						OP_READ: begin
							if (at_eof) begin
								res_q    <= mk(ST_EOF, '0, '0, pos_q, cur_q, 1'b1);
								strobe_q <= 1'b1;
								state_q  <= S_IDLE;
							end else if (len_n == 15'd0) begin
								res_q    <= mk(ST_OK, '0, '0, pos_q, cur_q, 1'b1);
								strobe_q <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								len_q    <= len_n;
								dvd_q    <= pos_q;
								dvs_q    <= cs;
								div_go_q <= 1'b1;
								state_q  <= S_RD_POS;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_SK_DIV: begin
					if (div_done) begin
						if (div_quot > {15'b0, TE17}) begin
							res_q    <= mk(ST_CHAIN_END, '0, '0, pos_q, cur_q, 1'b1);
							strobe_q <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							hops_q  <= div_quot[16:0];
							i_q     <= '0;
							c_q     <= first_q;
							state_q <= S_SK_WALK;
						end
					end
				end
				S_SK_WALK: begin
					if (w_done) begin
						cur_q    <= c_q;
						pos_q    <= tgt_q;
						res_q    <= mk(ST_OK, '0, '0, tgt_q, c_q, 1'b1);
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end else if (w_end) begin
						res_q    <= mk(ST_CHAIN_END, '0, '0, pos_q, cur_q, 1'b1);
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end else if (w_out) begin
						res_q    <= mk(ST_OUTSIDE, '0, '0, pos_q, cur_q, 1'b1);
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_SK_LOAD;
					end
				end
				S_SK_LOAD: begin
					c_q     <= ram_rdata;
					i_q     <= i_q + 17'd1;
					state_q <= S_SK_WALK;
				end
				S_RD_POS: begin
					if (div_done) begin
						inner_q  <= div_rem;
						dvd_q    <= root_dvd;
						dvs_q    <= {8'b0, bps_e};
						div_go_q <= 1'b1;
						state_q  <= S_RD_ROOT;
					end
				end
				S_RD_ROOT: begin
					if (div_done) begin
						base_q     <= {7'b0, cfg.reserved} + {4'b0, tbl_sectors} + div_quot[22:0];
						k_q        <= '0;
						done_cnt_q <= '0;
						state_q    <= S_RD_CHECK;
					end
				end
				S_RD_CHECK: begin
					if (c_end) begin
						res_q    <= mk(ST_CHAIN_END, '0, '0, pos_q, cur_q, 1'b1);
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end else if (c_out) begin
						res_q    <= mk(ST_OUTSIDE, '0, '0, pos_q, cur_q, 1'b1);
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						seg_q   <= seg_n;
						sec_q   <= sec_n;
						state_q <= S_RD_ADDR;
					end
				end
				S_RD_ADDR: begin
					addr_q     <= addr_n;
					nxt_q      <= ram_rdata;
					pos_q      <= pos_q + {17'b0, seg_q};
					done_cnt_q <= done_cnt_q + seg_q;
					// A segment that fills the rest of the cluster moves on to the next one.
					if ({6'b0, seg_q} == room) begin
						bnd_q   <= 1'b1;
						inner_q <= '0;
					end else begin
						bnd_q   <= 1'b0;
						inner_q <= inner_q + {6'b0, seg_q};
					end
					state_q <= S_RD_EMIT;
				end
				S_RD_EMIT: begin
					if (bnd_q) begin
						cur_q <= nxt_q;
					end
					res_q    <= mk(ST_OK, addr_q, seg_q, pos_q, bnd_q ? nxt_q : cur_q, last_n);
					strobe_q <= 1'b1;
					k_q      <= k_q + 6'd1;
					state_q  <= last_n ? S_IDLE : S_RD_CHECK;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && res_q.last |-> state_q == S_IDLE)
		else $error("final result left the sequencer busy");
	a_seg_ok: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && res_q.segment_bytes != 15'd0 |-> res_q.status == ST_OK)
		else $error("segment bytes on an error result");
	a_pos_size: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= size_q)
		else $error("file position beyond file size");
	a_seg_count: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= 6'(RESULTS_MAX))
		else $error("too many read segments");
`endif

endmodule
`default_nettype wire

// ===== src/fat16_file_offset_translator_unit.sv =====
// Top level of the FAT16 file offset translator: configuration and unit wiring.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
// A command is transferred at a rising edge with start high and busy low. op selects
// a table write, a file open, a seek or a read; the other input ports carry its fields.
// A two-entry queue sits between the command front end and the sequencer, so busy rises
// only when two commands are waiting. Each result appears for one cycle with
// result_strobe high; last marks the final result of a command. The receiver cannot
// stall, so results are never held.
// Sequencing: table writes and opens complete in the execute state. A seek makes one
// pass through the 32-step divider, then a walk state and a load state per cluster hop.
// A read makes two divider passes, then a check, an address and an emit state per
// segment, up to 33 segments. The divider and the single table read port are shared.
// Configuration is written through cfg_write, cfg_index and cfg_data while no command
// is pending. Reset clears the open file and loads the default volume geometry; the
// allocation table holds no defined contents until its entries are written.
module fat16_file_offset_translator_unit import fotr_pkg::*; #(
	parameter int TABLE_ENTRIES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  op,
	input  wire logic [15:0] table_index,
	input  wire logic [15:0] table_value,
	input  wire logic [15:0] start_cluster,
	input  wire logic [7:0]  attributes,
	input  wire logic [31:0] file_length,
	input  wire logic [32:0] seek_offset,
	input  wire logic [1:0]  seek_origin,
	input  wire logic [14:0] read_length,
	input  wire logic        cfg_write,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output logic             result_strobe,
	output logic [2:0]       status,
	output logic [35:0]      disk_address,
	output logic [14:0]      segment_bytes,
	output logic [31:0]      file_position,
	output logic [15:0]      cluster_now,
	output logic             last
);

	cfg_t    cfg_q;
	logic    cmd_valid;
	cmd_t    cmd;
	logic    cmd_pop;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bps      <= 13'd512;
			cfg_q.spc      <= 8'd4;
			cfg_q.reserved <= 16'd1;
			cfg_q.copies   <= 3'd2;
			cfg_q.spt      <= 16'd256;
			cfg_q.root     <= 16'd512;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_BPS:      cfg_q.bps      <= cfg_data[12:0];
				CFG_SPC:      cfg_q.spc      <= cfg_data[7:0];
				CFG_RESERVED: cfg_q.reserved <= cfg_data;
				CFG_COPIES:   cfg_q.copies   <= cfg_data[2:0];
				CFG_SPT:      cfg_q.spt      <= cfg_data;
				CFG_ROOT:     cfg_q.root     <= cfg_data;
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	fotr_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.table_index  (table_index),
		.table_value  (table_value),
		.start_cluster(start_cluster),
		.attributes   (attributes),
		.file_length  (file_length),
		.seek_offset  (seek_offset),
		.seek_origin  (seek_origin),
		.read_length  (read_length),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	fotr_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res       (res),
		.res_strobe(result_strobe)
	);

	assign status        = res.status;
	assign disk_address  = res.disk_address;
	assign segment_bytes = res.segment_bytes;
	assign file_position = res.file_position;
	assign cluster_now   = res.cluster_now;
	assign last          = res.last;

endmodule
`default_nettype wire
